### src/ows_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_COUNT = 3'd1,
    ST_GAP   = 3'd2,
    ST_WIDTH = 3'd3,
    ST_EMPTY = 3'd4,
    ST_RANGE = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_SAMPLE_UNIT = 3'd0,
    REG_GAP_LIMIT   = 3'd1,
    REG_ZERO_MIN    = 3'd2,
    REG_ZERO_MAX    = 3'd3,
    REG_ONE_MIN     = 3'd4
  } cfg_reg_e;

  localparam int unsigned CountW   = 7;
  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam int unsigned WordW    = 40;

  localparam logic [7:0]  SampleUnitRst = 8'd1;
  localparam logic [15:0] GapLimitRst   = 16'd650;
  localparam logic [15:0] ZeroMinRst    = 16'd1500;
  localparam logic [15:0] ZeroMaxRst    = 16'd2000;
  localparam logic [15:0] OneMinRst     = 16'd3500;

  // temperature conversion
  localparam logic [15:0] TempOffset = 16'h04C4;
  localparam logic [15:0] NegLimit   = 16'd3000;
  localparam logic [15:0] NegBase    = 16'd4096;
  localparam logic [15:0] TempMax    = 16'h0258;
  localparam logic [15:0] NegFlag    = 16'h8000;
  // floor(x / 9) = (x * 466034) >> 22 for any x below 2^19
  localparam logic [18:0] Recip9     = 19'd466034;
  localparam int unsigned Recip9Sh   = 22;

  localparam int unsigned OutDepth   = 4;
  localparam int unsigned BurstDepth = 2;

  typedef struct packed {
    logic [7:0]  sample_unit;
    logic [15:0] gap_limit_us;
    logic [15:0] zero_min_us;
    logic [15:0] zero_max_us;
    logic [15:0] one_min_us;
  } cfg_t;

  // a finished burst as the front hands it over
  typedef struct packed {
    logic [WordW-1:0] word;
    status_e          pre_status;
  } burst_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  rolling_code;
    logic [1:0]  channel;
    logic [15:0] temperature;
    logic [7:0]  humidity;
  } result_t;

endpackage

`default_nettype wire

### src/ows_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ows_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### src/ows_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ows_front #(
  parameter int unsigned PULSES_PER_BURST = 82
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ows_pkg::cfg_t   cfg_i,
  input  logic            accept_i,
  input  logic [15:0]     pulse_len_i,
  input  logic            last_pulse_i,
  output logic            burst_valid_o,
  output ows_pkg::burst_t burst_o
);

  import ows_pkg::*;

  localparam logic [CountW-1:0] NPulses = CountW'(PULSES_PER_BURST);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0]  word_q, word_d;
  status_e           ferr_q, ferr_d;

  logic [7:0]  su;
  logic [23:0] len_us;
  logic [24:0] len_us_plus;
  logic        decode, is_width, bit_one, width_err, gap_err;

  // limits stay in microseconds: p > floor(L/su) iff p*su > L,
  // and p < floor(L/su) iff p*su + su <= L
  assign su          = (cfg_i.sample_unit == '0) ? 8'd1 : cfg_i.sample_unit;
  assign len_us      = {8'd0, pulse_len_i} * {16'd0, su};
  assign len_us_plus = {1'b0, len_us} + {17'd0, su};

  assign decode    = (cnt_q >= CountW'(2)) && (cnt_q < NPulses);
  assign is_width  = !cnt_q[0];
  assign bit_one   = len_us > {8'd0, cfg_i.one_min_us};
  assign width_err = !bit_one && ((len_us > {8'd0, cfg_i.zero_max_us}) ||
                     (len_us_plus <= {9'd0, cfg_i.zero_min_us}));
  assign gap_err   = len_us > {8'd0, cfg_i.gap_limit_us};

  always_comb begin
    cnt_d  = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
    word_d = word_q;
    ferr_d = ferr_q;
    if (decode) begin
      if (is_width) begin
        word_d = {word_q[WordW-2:0], bit_one};
        if (width_err && ferr_q == ST_OK) begin
          ferr_d = ST_WIDTH;
        end
      end else if (gap_err && ferr_q == ST_OK) begin
        ferr_d = ST_GAP;
      end
    end
  end

  assign burst_valid_o      = accept_i && last_pulse_i;
  assign burst_o.word       = word_d;
  assign burst_o.pre_status = (cnt_d != NPulses) ? ST_COUNT : ferr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      word_q <= '0;
      ferr_q <= ST_OK;
    end else if (accept_i) begin
      if (last_pulse_i) begin
        cnt_q  <= '0;
        word_q <= '0;
        ferr_q <= ST_OK;
      end else begin
        cnt_q  <= cnt_d;
        word_q <= word_d;
        ferr_q <= ferr_d;
      end
    end
  end

endmodule

`default_nettype wire

### src/ows_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ows_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    burst_avail_i,
  input  ows_pkg::burst_t                         burst_i,
  output logic                                    burst_pop_o,
  input  logic [$clog2(ows_pkg::OutDepth+1)-1:0]  out_count_i,
  output logic                                    result_valid_o,
  output ows_pkg::result_t                        result_o
);

  import ows_pkg::*;

  localparam int unsigned OcW = $clog2(OutDepth + 1);

  logic [WordW-1:0] s1_word_q, s2_word_q;
  status_e          s1_pre_q, s2_pre_q;
  logic [18:0]      s1_x_q;
  logic [15:0]      s2_t_q;
  logic             s1_v_q, s2_v_q;

  logic [OcW:0]  used;
  logic [15:0]   t_off;
  logic [18:0]   x5;
  logic [37:0]   prod;

  // never start a burst the output queue might not have room for
  assign used        = {1'b0, out_count_i} + (OcW+1)'(s1_v_q) + (OcW+1)'(s2_v_q);
  assign burst_pop_o = burst_avail_i && (used < (OcW+1)'(OutDepth));

  assign t_off = {4'd0, burst_i.word[23:12]} - TempOffset;
  assign x5    = {1'b0, t_off, 2'b00} + {3'd0, t_off};
  assign prod  = {19'd0, s1_x_q} * {19'd0, Recip9};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= burst_pop_o;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_word_q <= burst_i.word;
    s1_pre_q  <= burst_i.pre_status;
    s1_x_q    <= x5;
    s2_word_q <= s1_word_q;
    s2_pre_q  <= s1_pre_q;
    s2_t_q    <= prod[Recip9Sh+15:Recip9Sh];
  end

  status_e     status;
  logic [15:0] temp;
  logic [15:0] neg_mag;

  assign neg_mag = NegBase - s2_t_q;

  always_comb begin
    status = ST_OK;
    temp   = s2_t_q;
    if (s2_pre_q != ST_OK) begin
      status = s2_pre_q;
    end else if (s2_word_q[39:24] == '0 || s2_word_q[23:0] == '0) begin
      status = ST_EMPTY;
    end else if (s2_t_q > NegLimit) begin
      if (s2_t_q > NegBase || neg_mag > TempMax) begin
        status = ST_RANGE;
      end else begin
        temp = neg_mag | NegFlag;
      end
    end else if (s2_t_q > TempMax) begin
      status = ST_RANGE;
    end
  end

  assign result_valid_o = s2_v_q;

  always_comb begin
    result_o.status       = status;
    result_o.rolling_code = '0;
    result_o.channel      = '0;
    result_o.temperature  = '0;
    result_o.humidity     = '0;
    if (status == ST_OK) begin
      result_o.rolling_code = s2_word_q[39:32];
      result_o.channel      = s2_word_q[1:0];
      result_o.temperature  = temp;
      result_o.humidity     = s2_word_q[11:4];
    end
  end

endmodule

`default_nettype wire

### src/ook_weather_sensor_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes 40-bit weather sensor bursts from a stream of pulse lengths. One
// pulse is taken every cycle while full is low: the front end multiplies the
// pulse length by the sample unit and compares it against the microsecond
// limits in the same cycle, shifting a bit into the word on each width pulse.
// A pulse marked last closes the burst and parks it in a two-entry burst queue;
// full rises only while that queue holds two bursts the back end has not
// started. The back end turns a burst into a result through temperature offset
// and times five, a reciprocal multiply for the divide by nine, then the range
// and status checks, with a register after each of the first two, and writes
// it into a four-entry result queue, starting a burst only when the queue is
// sure to have room. A result reaches the result ports through the burst queue,
// both back-end registers and the result queue. Configuration registers sit at
// byte offsets 0, 4, 8, 12 and 16 and should be written only between bursts.

module ook_weather_sensor_decoder #(
  parameter int unsigned PULSES_PER_BURST = 82
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [15:0] pulse_len_i,
  input  logic        last_pulse_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [7:0]  rolling_code_o,
  output logic [1:0]  channel_o,
  output logic [15:0] temperature_o,
  output logic [7:0]  humidity_o
);

  import ows_pkg::*;

  cfg_t     cfg_q;
  logic     cfg_wr;
  cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_unit  <= SampleUnitRst;
      cfg_q.gap_limit_us <= GapLimitRst;
      cfg_q.zero_min_us  <= ZeroMinRst;
      cfg_q.zero_max_us  <= ZeroMaxRst;
      cfg_q.one_min_us   <= OneMinRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SAMPLE_UNIT: cfg_q.sample_unit  <= pwdata[7:0];
        REG_GAP_LIMIT:   cfg_q.gap_limit_us <= pwdata[15:0];
        REG_ZERO_MIN:    cfg_q.zero_min_us  <= pwdata[15:0];
        REG_ZERO_MAX:    cfg_q.zero_max_us  <= pwdata[15:0];
        REG_ONE_MIN:     cfg_q.one_min_us   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SAMPLE_UNIT: prdata = {24'd0, cfg_q.sample_unit};
      REG_GAP_LIMIT:   prdata = {16'd0, cfg_q.gap_limit_us};
      REG_ZERO_MIN:    prdata = {16'd0, cfg_q.zero_min_us};
      REG_ZERO_MAX:    prdata = {16'd0, cfg_q.zero_max_us};
      REG_ONE_MIN:     prdata = {16'd0, cfg_q.one_min_us};
      default:         prdata = '0;
    endcase
  end

  // front end
  logic   accept;
  logic   burst_push;
  burst_t burst_in, burst_head;
  logic   burst_full, burst_empty, burst_pop;

  assign accept = push && !full;
  assign full   = burst_full;

  ows_front #(
    .PULSES_PER_BURST(PULSES_PER_BURST)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .pulse_len_i  (pulse_len_i),
    .last_pulse_i (last_pulse_i),
    .burst_valid_o(burst_push),
    .burst_o      (burst_in)
  );

  ows_queue #(
    .DEPTH(BurstDepth),
    .WIDTH($bits(burst_t))
  ) u_burst_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (burst_push),
    .data_i (burst_in),
    .pop_i  (burst_pop),
    .data_o (burst_head),
    .full_o (burst_full),
    .empty_o(burst_empty),
    .count_o()
  );

  // back end
  logic                         res_valid;
  result_t                      res_in, res_head;
  logic [$clog2(OutDepth+1)-1:0] res_count;
  logic                         res_full;

  ows_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_avail_i (!burst_empty),
    .burst_i       (burst_head),
    .burst_pop_o   (burst_pop),
    .out_count_i   (res_count),
    .result_valid_o(res_valid),
    .result_o      (res_in)
  );

  ows_queue #(
    .DEPTH(OutDepth),
    .WIDTH($bits(result_t))
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res_in),
    .pop_i  (pop),
    .data_o (res_head),
    .full_o (res_full),
    .empty_o(empty),
    .count_o(res_count)
  );

  // credit check in the back end keeps the result queue from overflowing
  logic unused_res_full;
  assign unused_res_full = res_full;

  assign status_o       = res_head.status;
  assign rolling_code_o = res_head.rolling_code;
  assign channel_o      = res_head.channel;
  assign temperature_o  = res_head.temperature;
  assign humidity_o     = res_head.humidity;

endmodule

`default_nettype wire

### src/ows_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ows_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pready,
  input logic [2:0]  status_o,
  input logic [7:0]  rolling_code_o,
  input logic [1:0]  channel_o,
  input logic [15:0] temperature_o,
  input logic [7:0]  humidity_o
);

  import ows_pkg::*;

  // nothing waits on the result side while in reset
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result waiting during reset");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o <= 3'(ST_RANGE)))
    else $error("status outside the defined codes");

  a_fields_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != 3'(ST_OK)) |->
      (rolling_code_o == '0 && channel_o == '0 && temperature_o == '0 &&
       humidity_o == '0))
    else $error("fields not cleared on a failed burst");

  // a good reading stays within plus or minus sixty degrees
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == 3'(ST_OK)) |->
      (temperature_o[14:0] <= 15'(TempMax)))
    else $error("accepted temperature out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind ook_weather_sensor_decoder ows_checker u_ows_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pready        (pready),
  .status_o      (status_o),
  .rolling_code_o(rolling_code_o),
  .channel_o     (channel_o),
  .temperature_o (temperature_o),
  .humidity_o    (humidity_o)
);

`default_nettype wire
